### rtl/rag_pkg.sv
// Shared types, constants and codes for the rational gcd-reduce block.
// No dependencies.
`default_nettype none
package rag_pkg;
  localparam int OPERAND_WIDTH_DEF = 32;
  localparam int FIELD_W = 32;
  localparam int MAG_W = 64;

  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_SUB = 2'd1;
  localparam logic [1:0] ACT_MUL = 2'd2;
  localparam logic [1:0] ACT_DIV = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;
  localparam logic [1:0] ST_OVF = 2'd3;

  // Datapath command codes.
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_LOAD = 3'd1;
  localparam logic [2:0] OP_MUL0 = 3'd2;
  localparam logic [2:0] OP_MUL1 = 3'd3;
  localparam logic [2:0] OP_COMB = 3'd4;
  localparam logic [2:0] OP_GSTART = 3'd5;
  localparam logic [2:0] OP_DSTART = 3'd6;
  localparam logic [2:0] OP_STEP = 3'd7;

  // The div_den flag selects the denominator division on DSTART and STEP.
  // With MUL1 it selects the cross product, and with GSTART it continues the
  // Euclid loop from the current pair instead of starting from the fraction.
  typedef struct packed {
    logic [2:0] op;
    logic       div_den;
  } rag_cmd_t;

  typedef struct packed {
    logic       zden;
    logic       divz;
    logic       q_zero;
    logic       div_done;
  } rag_stat_t;
endpackage
`default_nettype wire

### rtl/rag_if.sv
// Valid/ready channel interfaces for operand and result words.
`default_nettype none
interface rag_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] a_num;
  logic [31:0] a_den;
  logic [31:0] b_num;
  logic [31:0] b_den;
  modport source(output valid, action, a_num, a_den, b_num, b_den, input ready);
  modport sink(input valid, action, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rag_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] res_num;
  logic [31:0] res_den;
  logic [1:0]  status;
  modport source(output valid, res_num, res_den, status, input ready);
  modport sink(input valid, res_num, res_den, status, output ready);
endinterface
`default_nettype wire

### rtl/rag_datapath.sv
// Datapath: sign/magnitude operands, products, Euclid remainder and restoring
// divider sharing one bit-serial unit. Depends on rag_pkg.
`default_nettype none
module rag_datapath #(
  parameter int OPERAND_WIDTH = rag_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic [1:0]        action,
  input  wire logic [31:0]       a_num,
  input  wire logic [31:0]       a_den,
  input  wire logic [31:0]       b_num,
  input  wire logic [31:0]       b_den,
  input  wire rag_pkg::rag_cmd_t cmd,
  output rag_pkg::rag_stat_t     stat,
  output logic [31:0]            res_num,
  output logic [31:0]            res_den,
  output logic                   ovf
);
  import rag_pkg::*;
  localparam int W = OPERAND_WIDTH;
  localparam int SW = $clog2(MAG_W + 1);

  logic [1:0]   act;
  logic [W-1:0] anm, adm, bnm, bdm;
  logic         ans, ads, bns, bds;
  logic [MAG_W-1:0] p0, p1, dm, nm;
  logic         p0s, p1s, ns, ds;
  logic [MAG_W-1:0] gp, gq, rem, quo, dvs, nq, dq;
  logic [SW-1:0] cnt;

  function automatic logic [W-1:0] fmag(input logic [31:0] v);
    logic [W-1:0] x;
    x = v[W-1:0];
    fmag = x[W-1] ? (~x + 1'b1) : x;
  endfunction

  // Multiplier operand select: step 0 forms p0, step 1 forms the denominator,
  // and step 1 with the flag set forms the cross product p1.
  logic [W-1:0] ma, mb;
  logic         msg;
  always_comb begin
    ma = anm; mb = bdm; msg = ans ^ bds;
    if (cmd.op == OP_MUL0) begin
      if (act == ACT_MUL) begin
        mb = bnm; msg = ans ^ bns;
      end
    end else if (cmd.div_den) begin
      ma = adm; mb = bnm; msg = ads ^ bns;
    end else begin
      ma = adm; mb = (act == ACT_MUL || act == ACT_ADD || act == ACT_SUB) ? bdm : bnm;
      msg = ads ^ ((act == ACT_DIV) ? bns : bds);
    end
  end
  logic [MAG_W-1:0] mprod;
  assign mprod = MAG_W'(ma) * MAG_W'(mb);

  // Bit-serial remainder/quotient step over the shared divisor.
  logic [MAG_W:0]   trial;
  logic [MAG_W-1:0] dsrc;
  assign dsrc = quo;
  assign trial = {rem, dsrc[MAG_W-1]} - {1'b0, dvs};

  logic [MAG_W-1:0] cross_s;
  logic cross_n;
  always_comb begin
    logic q1s;
    q1s = (act == ACT_SUB) ? ~p1s : p1s;
    if (p1 == '0) q1s = 1'b0;
    if (p0s == q1s) begin
      cross_s = p0 + p1; cross_n = p0s;
    end else if (p0 >= p1) begin
      cross_s = p0 - p1; cross_n = p0s;
    end else begin
      cross_s = p1 - p0; cross_n = q1s;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        act <= action;
        anm <= fmag(a_num); ans <= a_num[W-1];
        adm <= fmag(a_den); ads <= a_den[W-1];
        bnm <= fmag(b_num); bns <= b_num[W-1];
        bdm <= fmag(b_den); bds <= b_den[W-1];
      end
      OP_MUL0: begin
        p0 <= mprod; p0s <= msg && (mprod != '0);
      end
      OP_MUL1: begin
        if (cmd.div_den) begin
          p1 <= mprod; p1s <= msg && (mprod != '0);
        end else begin
          dm <= mprod; ds <= msg;
        end
      end
      OP_COMB: begin
        if (act == ACT_MUL || act == ACT_DIV) begin
          nm <= p0; ns <= p0s;
        end else begin
          nm <= cross_s; ns <= cross_n && (cross_s != '0);
        end
      end
      OP_GSTART: begin
        if (cmd.div_den) begin
          quo <= gp; dvs <= gq;
        end else begin
          gp <= nm; gq <= dm;
          quo <= nm; dvs <= dm;
        end
        rem <= '0; cnt <= '0;
      end
      OP_DSTART: begin
        quo <= cmd.div_den ? dm : nm; dvs <= gp; rem <= '0; cnt <= '0;
      end
      OP_STEP: begin
        if (!trial[MAG_W]) begin
          rem <= trial[MAG_W-1:0]; quo <= {quo[MAG_W-2:0], 1'b1};
        end else begin
          rem <= {rem[MAG_W-2:0], quo[MAG_W-1]}; quo <= {quo[MAG_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == SW'(MAG_W - 1)) begin
          // One Euclid remainder finished: rotate unless this was a divide.
          if (!cmd.div_den && stat.q_zero == 1'b0 && dvs == gq) begin
            gp <= gq;
            gq <= trial[MAG_W] ? {rem[MAG_W-2:0], quo[MAG_W-1]} : trial[MAG_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  logic [MAG_W-1:0] qfin;
  assign qfin = trial[MAG_W] ? {quo[MAG_W-2:0], 1'b0} : {quo[MAG_W-2:0], 1'b1};
  always_ff @(posedge clk) begin
    if (cmd.op == OP_STEP && cnt == SW'(MAG_W - 1)) begin
      if (cmd.div_den) dq <= qfin; else if (dvs != gq) nq <= qfin;
    end
  end

  assign stat.zden = (adm == '0) || (bdm == '0);
  assign stat.divz = (act == ACT_DIV) && (bnm == '0);
  assign stat.q_zero = (gq == '0);
  assign stat.div_done = (cnt == SW'(MAG_W - 1));

  localparam logic [MAG_W-1:0] LIM = MAG_W'(1) << (W - 1);
  logic nneg, dneg;
  assign nneg = ns && (nq != '0);
  assign dneg = ds && (dq != '0);
  assign ovf = (nneg ? nq > LIM : nq >= LIM) || (dneg ? dq > LIM : dq >= LIM);
  assign res_num = nneg ? 32'(-nq) : nq[31:0];
  assign res_den = dneg ? 32'(-dq) : dq[31:0];
endmodule
`default_nettype wire

### rtl/rag_ctrl.sv
// Controller: sequences load, products, Euclid loop and the two divisions.
// Depends on rag_pkg.
`default_nettype none
module rag_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire rag_pkg::rag_stat_t stat,
  input  wire logic               ovf,
  output rag_pkg::rag_cmd_t       cmd,
  output logic [1:0]              status
);
  import rag_pkg::*;
  localparam logic [3:0] S_IDLE = 4'd0, S_CHK = 4'd1, S_M0 = 4'd2, S_M1 = 4'd3,
    S_CMB = 4'd4, S_GS = 4'd5, S_GL = 4'd6, S_GT = 4'd7, S_NS = 4'd8,
    S_NL = 4'd9, S_DS = 4'd10, S_DL = 4'd11, S_FIN = 4'd12, S_OUT = 4'd13,
    S_M2 = 4'd14;
  logic [3:0] state, state_next;
  logic [1:0] st_next;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state; st_next = status; cmd = '{op: OP_NONE, div_den: 1'b0};
    unique case (state)
      S_IDLE: if (in_valid) begin cmd.op = OP_LOAD; state_next = S_CHK; end
      S_CHK: begin
        if (stat.zden) begin st_next = ST_ZDEN; state_next = S_OUT; end
        else if (stat.divz) begin st_next = ST_DIVZ; state_next = S_OUT; end
        else begin st_next = ST_OK; state_next = S_M0; end
      end
      S_M0: begin cmd.op = OP_MUL0; state_next = S_M1; end
      S_M1: begin cmd.op = OP_MUL1; state_next = S_M2; end
      S_M2: begin cmd = '{op: OP_MUL1, div_den: 1'b1}; state_next = S_CMB; end
      S_CMB: begin cmd.op = OP_COMB; state_next = S_GS; end
      S_GS: begin cmd.op = OP_GSTART; state_next = S_GL; end
      S_GL: begin
        cmd.op = OP_STEP;
        if (stat.div_done) state_next = S_GT;
      end
      // After a remainder, gq holds the new remainder; restart or finish.
      S_GT: begin
        if (stat.q_zero) state_next = S_NS;
        else begin cmd = '{op: OP_GSTART, div_den: 1'b1}; state_next = S_GL; end
      end
      S_NS: begin cmd.op = OP_DSTART; state_next = S_NL; end
      S_NL: begin cmd.op = OP_STEP; if (stat.div_done) state_next = S_DS; end
      S_DS: begin cmd = '{op: OP_DSTART, div_den: 1'b1}; state_next = S_DL; end
      S_DL: begin
        cmd = '{op: OP_STEP, div_den: 1'b1};
        if (stat.div_done) state_next = S_FIN;
      end
      S_FIN: begin if (ovf) st_next = ST_OVF; state_next = S_OUT; end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; status <= ST_OK;
    end else begin
      state <= state_next; status <= st_next;
    end
  end
endmodule
`default_nettype wire

### rtl/rational_arith_gcd_reduce.sv
// Rational add/sub/mul/div with Euclidean gcd reduction, one word at a time.
// Sequence per word: load and check, products, Euclid remainder steps, then
// the two quotient divisions, then the result is held until taken; error
// results go straight to the output. All share one 64-bit restoring
// divider, one bit a cycle. A new word is accepted only when idle.
// Synchronous active-high reset returns the controller to idle.
`default_nettype none
module rational_arith_gcd_reduce #(
  parameter int OPERAND_WIDTH = rag_pkg::OPERAND_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  rag_in_if.sink   in_ch,
  rag_out_if.source out_ch
);
  import rag_pkg::*;
  rag_cmd_t cmd;
  rag_stat_t stat;
  logic ovf;
  logic [1:0] status;
  logic [31:0] rn, rd;

  rag_ctrl u_ctrl (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat, .ovf, .cmd, .status
  );
  rag_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk, .action(in_ch.action), .a_num(in_ch.a_num), .a_den(in_ch.a_den),
    .b_num(in_ch.b_num), .b_den(in_ch.b_den), .cmd, .stat,
    .res_num(rn), .res_den(rd), .ovf
  );
  assign out_ch.status = status;
  assign out_ch.res_num = (status == ST_OK) ? rn : '0;
  assign out_ch.res_den = (status == ST_OK) ? rd : '0;

`ifndef SYNTHESIS
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid)) else $error("input and output both open");
  a_den: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && status == ST_OK) |-> out_ch.res_den != '0)
    else $error("zero denominator on ok result");
`endif
endmodule
`default_nettype wire
